>>> design/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants of the k-way merge block
// Command codes, register map and the control group of the compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

  localparam int DATA_W = 32;
  localparam int SRC_W  = 3;
  localparam int NUM_W  = 4;

  // Command codes carried in the low bits of the input transaction
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Register map, word index
  localparam logic REG_NUM_LISTS = 1'b0;

  localparam logic [NUM_W-1:0] NUM_LISTS_RESET = 4'd8;

  // Control group driven by the sequencer into the compare unit
  typedef struct packed {
    logic start;     // forget the current best, a new scan begins
    logic cand_vld;  // a list head is presented for comparison
  } cmp_ctl_t;

endpackage

`default_nettype wire

>>> design/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/kwm_cmp.sv
// ----------------------------------------------------------------------------
// kwm_cmp: shared signed compare unit with best-head register
// Keeps the smallest head seen in a scan; ties keep the earlier list.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_cmp #(
  parameter int LW = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire kwm_pkg::cmp_ctl_t                   ctl,
  input  wire logic signed [kwm_pkg::DATA_W-1:0]   cand_value,
  input  wire logic        [LW-1:0]                cand_list,
  output logic                                     take,
  output logic                                     found,
  output logic signed      [kwm_pkg::DATA_W-1:0]   best_value,
  output logic             [LW-1:0]                best_list
);

  logic                                 found_r, found_nxt;
  logic signed [kwm_pkg::DATA_W-1:0]    best_value_r;
  logic        [LW-1:0]                 best_list_r;

  // strict less-than keeps the lowest list index on ties
  assign take = ctl.cand_vld && (!found_r || (cand_value < best_value_r));

  always_comb begin
    found_nxt = found_r;
    if (ctl.start) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.start) begin
      best_value_r <= cand_value;
      best_list_r  <= cand_list;
    end
  end

  assign found      = found_r;
  assign best_value = best_value_r;
  assign best_list  = best_list_r;

endmodule

`default_nettype wire

>>> design/k_way_merge_linear_scan.sv
// ----------------------------------------------------------------------------
// k_way_merge_linear_scan: k-way merge by a linear scan of the list heads
// A pop scans min(num_lists, LISTS) list heads, one head per cycle through the RAMs,
// and it can be held by an out_tready stall before its result is placed.
// Synchronous active-low reset empties all lists at once and sets num_lists to 8.
// ----------------------------------------------------------------------------
`default_nettype none

// Structure
//   cnt RAM   : per list {fill, cursor}, with one valid bit per list in flops so
//               that reset and clear empty every list at once.
//   store RAM : LISTS x LIST_DEPTH words, list j occupies words j*LIST_DEPTH on.
//   kwm_cmp   : the one signed comparator, holds the best head of the scan.
// A pop runs a three-stage scan pipeline: read counts of list j, read the head
// word of list j if it has unread entries, compare it. One list enters per
// cycle. After the pipe drains, the winner's cursor is advanced and the result
// is placed in the output register. The block takes one command at a time;
// in_tready is high only while the sequencer is idle.

module k_way_merge_linear_scan #(
  parameter int LISTS      = 8,
  parameter int LIST_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] command, [4:2] list_index, [36:5] value, [39:37] zero
  input  wire logic [39:0] in_tdata,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] merged_value, [34:32] source_list, [39:35] zero
  output logic      [39:0] out_tdata,
  // [0] empty_res
  output logic      [0:0]  out_tuser,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int LW  = $clog2(LISTS);
  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int SD  = LISTS * LIST_DEPTH;
  localparam int SAW = $clog2(SD);
  localparam int DW  = kwm_pkg::DATA_W;
  localparam int NW  = kwm_pkg::NUM_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_SCAN = 4'b0100,
    S_POST = 4'b1000
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [NW-1:0] num_lists_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == kwm_pkg::REG_NUM_LISTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_lists_r <= kwm_pkg::NUM_LISTS_RESET;
    end else if (cfg_wr) begin
      num_lists_r <= cfg_pwdata[NW-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == kwm_pkg::REG_NUM_LISTS) ? 32'(num_lists_r) : 32'd0;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  kwm_pkg::cmd_t   in_cmd;
  logic [2:0]      in_list;
  logic [DW-1:0]   in_value;
  logic            in_acc;
  logic            in_ok;
  logic [LW-1:0]   in_idx;
  logic [NW-1:0]   scan_len;

  assign in_cmd   = kwm_pkg::cmd_t'(in_tdata[1:0]);
  assign in_list  = in_tdata[4:2];
  assign in_value = in_tdata[36:5];
  assign in_acc   = in_tvalid && in_tready;
  // a load naming a list beyond LISTS is dropped; point it at list 0 meanwhile
  assign in_ok    = 32'(in_list) < LISTS;
  assign in_idx   = in_ok ? LW'(in_list) : '0;
  // clamp the scan to the lists that exist
  assign scan_len = (32'(num_lists_r) < LISTS) ? num_lists_r : NW'(LISTS);

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_t          state_r, state_nxt;
  logic [LW-1:0]   ld_idx_r;
  logic            ld_ok_r;
  logic [DW-1:0]   ld_val_r;
  logic [NW-1:0]   issue_r, issue_nxt;
  logic [NW-1:0]   scan_r;
  logic            issuing;

  // scan pipeline
  logic            s1_v_r;
  logic [LW-1:0]   s1_j_r;
  logic            s2_v_r;
  logic [LW-1:0]   s2_j_r;
  logic [CW-1:0]   s2_fill_r, s2_cur_r;
  logic [CW-1:0]   best_fill_r, best_cur_r;

  // list valid bits: a list without its bit reads as empty
  logic [LISTS-1:0] lv_r, lv_nxt;

  // count RAM
  logic            cnt_we;
  logic [LW-1:0]   cnt_waddr, cnt_raddr, cnt_ridx_r;
  logic [2*CW-1:0] cnt_wdata, cnt_rdata;
  logic [CW-1:0]   rd_fill, rd_cur;

  // store RAM
  logic            st_we;
  logic [SAW-1:0]  st_waddr, st_raddr;
  logic [DW-1:0]   st_wdata, st_rdata;
  logic            s1_has;

  // compare unit
  kwm_pkg::cmp_ctl_t cmp_ctl;
  logic              cmp_take, cmp_found;
  logic signed [DW-1:0] cmp_best;
  logic [LW-1:0]        cmp_best_list;

  // output register
  logic            out_v_r, out_v_nxt;
  logic [DW-1:0]   out_val_r;
  logic [2:0]      out_src_r;
  logic            out_empty_r;
  logic            out_free;
  logic            post_fire;

  assign in_tready = (state_r == S_IDLE);
  assign issuing   = (issue_r < scan_r);
  assign out_free  = !out_v_r || out_tready;
  assign post_fire = (state_r == S_POST) && out_free;

  always_comb begin
    state_nxt = state_r;
    issue_nxt = issue_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          issue_nxt = '0;
          if (in_cmd == kwm_pkg::CMD_LOAD) begin
            state_nxt = S_LOAD;
          end else if (in_cmd == kwm_pkg::CMD_POP) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_LOAD: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (issuing) begin
          issue_nxt = issue_r + 1'b1;
        end else if (!s1_v_r && !s2_v_r) begin
          // pipe drained, the compare unit holds the winner
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      issue_r <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      lv_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
      s1_v_r  <= (state_r == S_SCAN) && issuing;
      s2_v_r  <= s1_has;
      lv_r    <= lv_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // hold the command operands for the following cycles; also step the scan pipeline
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ld_idx_r <= in_idx;
      ld_ok_r  <= in_ok;
      ld_val_r <= in_value;
      scan_r   <= scan_len;
    end
    s1_j_r     <= LW'(issue_r);
    s2_j_r     <= s1_j_r;
    s2_fill_r  <= rd_fill;
    s2_cur_r   <= rd_cur;
    cnt_ridx_r <= cnt_raddr;
    if (cmp_take) begin
      best_fill_r <= s2_fill_r;
      best_cur_r  <= s2_cur_r;
    end
  end

  // --------------------------------------------------------------------------
  // Count RAM access
  // --------------------------------------------------------------------------
  assign cnt_raddr = (state_r == S_IDLE) ? in_idx : LW'(issue_r);
  assign rd_fill   = lv_r[cnt_ridx_r] ? cnt_rdata[2*CW-1:CW] : '0;
  assign rd_cur    = lv_r[cnt_ridx_r] ? cnt_rdata[CW-1:0]    : '0;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = ld_idx_r;
    cnt_wdata = {rd_fill + 1'b1, rd_cur};
    st_we     = 1'b0;
    lv_nxt    = lv_r;
    if ((state_r == S_LOAD) && ld_ok_r && (rd_fill < CW'(LIST_DEPTH))) begin
      // append behind the last entry of the list
      cnt_we           = 1'b1;
      st_we            = 1'b1;
      lv_nxt[ld_idx_r] = 1'b1;
    end else if (post_fire && cmp_found) begin
      // advance the winner's cursor
      cnt_we    = 1'b1;
      cnt_waddr = cmp_best_list;
      cnt_wdata = {best_fill_r, best_cur_r + 1'b1};
    end
    if (in_acc && (in_cmd == kwm_pkg::CMD_CLEAR)) begin
      lv_nxt = '0;
    end
  end

  kwm_ram #(
    .WIDTH (2 * CW),
    .DEPTH (LISTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // --------------------------------------------------------------------------
  // Store RAM access
  // --------------------------------------------------------------------------
  assign s1_has   = s1_v_r && (rd_cur < rd_fill);
  assign st_raddr = SAW'(SAW'(s1_j_r) * SAW'(LIST_DEPTH) + SAW'(rd_cur));
  assign st_waddr = SAW'(SAW'(ld_idx_r) * SAW'(LIST_DEPTH) + SAW'(rd_fill));
  assign st_wdata = ld_val_r;

  kwm_ram #(
    .WIDTH (DW),
    .DEPTH (SD)
  ) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // --------------------------------------------------------------------------
  // Compare unit
  // --------------------------------------------------------------------------
  assign cmp_ctl.start    = in_acc && (in_cmd == kwm_pkg::CMD_POP);
  assign cmp_ctl.cand_vld = s2_v_r;

  kwm_cmp #(
    .LW (LW)
  ) u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (cmp_ctl),
    .cand_value ($signed(st_rdata)),
    .cand_list  (s2_j_r),
    .take       (cmp_take),
    .found      (cmp_found),
    .best_value (cmp_best),
    .best_list  (cmp_best_list)
  );

  // --------------------------------------------------------------------------
  // Output register: drop the transaction once taken, load a new pop result
  // --------------------------------------------------------------------------
  always_comb begin
    out_v_nxt = out_v_r && !out_tready;
    if (post_fire) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (post_fire) begin
      if (cmp_found) begin
        out_val_r   <= cmp_best;
        out_src_r   <= 3'(cmp_best_list);
        out_empty_r <= 1'b0;
      end else begin
        out_val_r   <= '0;
        out_src_r   <= '0;
        out_empty_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_src_r, out_val_r};
  assign out_tuser  = out_empty_r;

endmodule

`default_nettype wire

>>> bench/kwm_checker.sv
// ----------------------------------------------------------------------------
// kwm_checker: result predictor and scoreboard for the k-way merge block
// Watches the command, result and register channels, keeps its own lists,
// predicts the result of every pop and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwm_checker
  import kwm_pkg::*;
#(
  parameter int LISTS      = 8,
  parameter int LIST_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          mismatches,
  output int          results_due,
  output int          results_seen
);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [SRC_W-1:0]         src;
    logic                     empty;
  } merge_result_t;

  logic signed [DATA_W-1:0] list_mem [LISTS][LIST_DEPTH];
  int unsigned              fill     [LISTS];
  int unsigned              cursor   [LISTS];
  logic [NUM_W-1:0]         lists_on;
  merge_result_t            merged_q [$];

  initial begin
    mismatches   = 0;
    results_due  = 0;
    results_seen = 0;
  end

  function automatic void empty_lists();
    for (int j = 0; j < LISTS; j++) begin
      fill[j]   = 0;
      cursor[j] = 0;
    end
  endfunction

  // Advance the list state by one command; a pop queues its merged result.
  function automatic void apply_command(cmd_t cmd, logic [SRC_W-1:0] idx,
                                        logic signed [DATA_W-1:0] v);
    int                       scan;
    int                       best_list;
    logic signed [DATA_W-1:0] best;
    bit                       found;
    merge_result_t            r;
    case (cmd)
      CMD_LOAD: begin
        // drop loads into a full list or a list that does not exist
        if (idx < LISTS && fill[idx] < LIST_DEPTH) begin
          list_mem[idx][fill[idx]] = v;
          fill[idx]++;
        end
      end
      CMD_CLEAR: begin
        empty_lists();
      end
      CMD_POP: begin
        scan      = (lists_on < LISTS) ? int'(lists_on) : LISTS;
        found     = 1'b0;
        best      = '0;
        best_list = 0;
        // strict less-than keeps ties on the lowest list
        for (int j = 0; j < scan; j++) begin
          if (cursor[j] < fill[j] && (!found || list_mem[j][cursor[j]] < best)) begin
            best      = list_mem[j][cursor[j]];
            best_list = j;
            found     = 1'b1;
          end
        end
        if (found) begin
          cursor[best_list]++;
          r.value = best;
          r.src   = best_list[SRC_W-1:0];
          r.empty = 1'b0;
        end else begin
          r.value = '0;
          r.src   = '0;
          r.empty = 1'b1;
        end
        merged_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    merge_result_t want;
    if (!rst_n) begin
      empty_lists();
      lists_on = NUM_LISTS_RESET;
      merged_q.delete();
    end else begin
      // results first: a pop accepted at this edge cannot have its result here
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (merged_q.size() == 0) begin
          $error("unexpected result: merged_value %0d source_list %0d empty_res %0d",
                 $signed(out_tdata[31:0]), out_tdata[34:32], out_tuser[0]);
          mismatches++;
        end else begin
          want = merged_q.pop_front();
          if (out_tdata[31:0] !== want.value) begin
            $error("merged_value: expected %0d, got %0d", want.value,
                   $signed(out_tdata[31:0]));
            mismatches++;
          end
          if (out_tdata[34:32] !== want.src) begin
            $error("source_list: expected %0d, got %0d", want.src, out_tdata[34:32]);
            mismatches++;
          end
          if (out_tuser[0] !== want.empty) begin
            $error("empty_res: expected %0d, got %0d", want.empty, out_tuser[0]);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        apply_command(cmd_t'(in_tdata[1:0]), in_tdata[4:2], in_tdata[36:5]);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          (cfg_paddr >> 2) == REG_NUM_LISTS)
        lists_on = cfg_pwdata[NUM_W-1:0];
    end
    results_due <= merged_q.size();
  end

endmodule

>>> bench/tb_k_way_merge_linear_scan.sv
// ----------------------------------------------------------------------------
// tb_k_way_merge_linear_scan: stimulus and verdict for the k-way merge block
// Drives load, pop, clear and unused commands in bursts against a stalling
// result receiver, steps num_lists through a plan that spans its range, and leaves prediction
// and comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_k_way_merge_linear_scan;
  import kwm_pkg::*;

  localparam int LISTS       = 8;
  localparam int LIST_DEPTH  = 256;
  // settle time that covers the slowest pop and a load, with margin
  localparam int SETTLE_CYCLES = LISTS + 10;
  // random commands per num_lists setting
  localparam int PHASE_ITEMS = 100;
  localparam int PLAN_LEN    = 10;
  // list counts visited in order: empty scan, single list, beyond LISTS, full width
  localparam logic [NUM_W-1:0] LISTS_PLAN [PLAN_LEN] =
    '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd2, 4'd7, 4'd12, 4'd5, 4'd8};
  // register word 0 holds num_lists; word 1 is unmapped
  localparam logic [2:0] ADDR_NUM_LISTS = {REG_NUM_LISTS, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int results_due;
  int results_seen;

  // sender burst state and transaction tallies for the summary
  int burst_left;
  int items_sent;
  int loads_sent;
  int pops_sent;
  int clears_sent;
  int unused_sent;
  int settings_run;
  bit overflow_done;

  // receiver stall pattern
  int         stall_mode;
  int         stall_left;
  logic [7:0] beat;

  k_way_merge_linear_scan #(
    .LISTS      (LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  kwm_checker #(
    .LISTS      (LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .mismatches   (mismatches),
    .results_due  (results_due),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: switch at random between always ready, coin-flip,
  // one beat in eight and mostly ready, so stalls land on every pop phase.
  always @(posedge clk) begin
    beat <= beat + 8'd1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (beat[2:0] == 3'd0);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Present one command and hold it until the block takes the transaction.
  // At the end of a burst, drop tvalid for a random gap; the next call raises
  // it again, so tvalid never gets two updates in one time step.
  task automatic send_item(cmd_t cmd, logic [SRC_W-1:0] idx, logic [DATA_W-1:0] v);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, v, idx, cmd};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    case (cmd)
      CMD_LOAD:  loads_sent++;
      CMD_POP:   pops_sent++;
      CMD_CLEAR: clears_sent++;
      default:   unused_sent++;
    endcase
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
  endtask

  // Hold off the sender until every predicted result has arrived, then let
  // the block finish any load still in flight.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Only the low bits count; fill the rest with noise.
  task automatic set_lists(logic [NUM_W-1:0] n);
    drain();
    write_reg(ADDR_NUM_LISTS, ($urandom & 32'hFFFF_FFF0) | 32'(n));
    settings_run++;
  endtask

  // Value styles: full range, a narrow band around zero that forces ties,
  // and the two ends of the signed range.
  function automatic logic [DATA_W-1:0] pick_value(int style);
    case (style)
      0:       return $urandom;
      1:       return DATA_W'(int'($urandom_range(0, 15)) - 8);
      default: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                           : 32'h7FFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  // Corners: both ends of the value range, duplicates, a tie across lists,
  // an out-of-order load, a load behind popped entries, the unused command,
  // a clear of filled lists and pops past exhaustion, all at num_lists = 8.
  task automatic directed_checks();
    send_item(CMD_LOAD, 3'd0, 32'h8000_0000);
    send_item(CMD_LOAD, 3'd0, 32'h8000_0000);
    send_item(CMD_LOAD, 3'd0, 32'h7FFF_FFFF);
    send_item(CMD_LOAD, 3'd7, 32'h7FFF_FFFF);
    send_item(CMD_LOAD, 3'd1, 32'h0000_0000);
    send_item(CMD_LOAD, 3'd1, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 3'd3, -32'sd5);
    send_item(CMD_LOAD, 3'd5, -32'sd5);
    send_item(CMD_NONE, 3'd7, 32'hFFFF_FFFF);
    repeat (3) send_item(CMD_POP, 3'd0, 32'h0);
    send_item(CMD_LOAD, 3'd0, -32'sd3);
    repeat (8) send_item(CMD_POP, 3'd7, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 3'd2, 32'd123);
    send_item(CMD_CLEAR, 3'd0, 32'h0);
    send_item(CMD_POP, 3'd0, 32'h0);
  endtask

  // Well-formed merge: ascending runs into random lists, interleaved across
  // lists, then pops until everything scanned is gone plus a few empty pops.
  // With in_order clear, the runs are shuffled to exercise unsorted heads.
  task automatic merge_batch(bit in_order);
    int per_list [LISTS][$];
    int total;
    int loaded;
    int pick;
    int n;
    int style;
    style = $urandom_range(0, 2);
    total = 0;
    for (int j = 0; j < LISTS; j++) begin
      n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      for (int k = 0; k < n; k++)
        per_list[j].push_back(int'(pick_value(style)));
      if (in_order)
        per_list[j].sort();
      total += n;
    end
    loaded = total;
    while (total > 0) begin
      do pick = $urandom_range(0, LISTS - 1); while (per_list[pick].size() == 0);
      send_item(CMD_LOAD, pick[SRC_W-1:0], per_list[pick].pop_front());
      total--;
      // occasionally pop while loading, so loads land behind popped entries
      if ($urandom_range(0, 9) == 0)
        send_item(CMD_POP, 3'($urandom), $urandom);
    end
    // don't-care fields of a pop carry noise
    repeat (loaded + $urandom_range(1, 3)) send_item(CMD_POP, 3'($urandom), $urandom);
  endtask

  // Any command with any fields, the unused one included.
  task automatic noise_run();
    repeat ($urandom_range(4, 16))
      send_item(cmd_t'($urandom_range(0, 3)), 3'($urandom), $urandom);
  endtask

  // Overfill one list past its depth, then pop it dry: the extra loads drop.
  task automatic overflow_run();
    int vals [$];
    int idx;
    idx = $urandom_range(0, LISTS - 1);
    for (int k = 0; k < LIST_DEPTH + 4; k++)
      vals.push_back(int'(pick_value(0)));
    vals.sort();
    send_item(CMD_CLEAR, 3'd0, 32'h0);
    foreach (vals[k])
      send_item(CMD_LOAD, idx[SRC_W-1:0], vals[k]);
    repeat (LIST_DEPTH + 2) send_item(CMD_POP, 3'($urandom), $urandom);
  endtask

  initial begin
    int phase_end;
    int r;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    stall_mode   = 0;
    stall_left   = 0;
    beat         = '0;
    burst_left   = 8;
    items_sent   = 0;
    loads_sent   = 0;
    pops_sent    = 0;
    clears_sent  = 0;
    unused_sent  = 0;
    settings_run = 0;
    overflow_done = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of num_lists is in force here
    directed_checks();

    // a write to the unmapped word must leave num_lists alone
    drain();
    write_reg(ADDR_UNMAPPED, 32'h0000_0003);
    merge_batch(1'b1);

    for (int p = 0; p < PLAN_LEN; p++) begin
      set_lists(LISTS_PLAN[p]);
      if (LISTS_PLAN[p] == NUM_W'(LISTS) && !overflow_done) begin
        overflow_run();
        overflow_done = 1'b1;
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 19);
        if (r < 12)
          merge_batch(1'b1);
        else if (r < 14)
          merge_batch(1'b0);
        else if (r < 17)
          noise_run();
        else if (r < 18) begin
          send_item(CMD_CLEAR, 3'($urandom), $urandom);
          repeat ($urandom_range(1, 3)) send_item(CMD_POP, 3'($urandom), $urandom);
        end else if (r < 19)
          drain();   // hold the sender until the result stream is empty
        else
          merge_batch(1'b1);
      end
    end

    drain();
    $display("Sent %0d commands: %0d loads, %0d pops, %0d clears, %0d unused",
             items_sent, loads_sent, pops_sent, clears_sent, unused_sent);
    $display("Checked %0d merge results over %0d num_lists settings, incl. 0, 1, 8, 15",
             results_seen, settings_run);
    if (mismatches == 0 && results_due == 0) begin
      $display("[k_way_merge_linear_scan] OK");
    end else begin
      $display("[k_way_merge_linear_scan] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[k_way_merge_linear_scan] ERROR");
    $finish;
  end

endmodule

>>> files.f
design/kwm_pkg.sv
design/kwm_ram.sv
design/kwm_cmp.sv
design/k_way_merge_linear_scan.sv
bench/kwm_checker.sv
bench/tb_k_way_merge_linear_scan.sv
